// ----- rtl/switch_bank_debouncer_macros.svh -----
// Assertion macros for the switch bank debouncer.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef SWITCH_BANK_DEBOUNCER_MACROS_SVH
`define SWITCH_BANK_DEBOUNCER_MACROS_SVH

`ifndef ASSERT_OFF

// Check an expression at every clock edge outside reset
`define SBD_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("switch_bank_debouncer: check failed");

// Check that a condition implies a consequence in the same cycle
`define SBD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("switch_bank_debouncer: implication failed");

// Check that a condition implies a consequence in the next cycle
`define SBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("switch_bank_debouncer: next-cycle check failed");

`else

`define SBD_ASSERT_ALWAYS(label, expr)
`define SBD_ASSERT_IMPLIES(label, ante, cons)
`define SBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/swdb_pkg.sv -----
// Shared types and constants for the switch bank debouncer.
// No dependencies; used by swdb_step and switch_bank_debouncer.
package swdb_pkg;

    localparam int PIN_W        = 4;
    localparam int CNT_W        = 16;
    localparam int NUM_SWITCHES = 4;

    // Switches beyond the bank or beyond the pin field never read as pressed
    localparam logic [PIN_W-1:0] SWITCH_MASK =
        (NUM_SWITCHES >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((1 << NUM_SWITCHES) - 1);

    localparam logic [CNT_W-1:0] SETTLE_DELAY_RST = 16'd50;
    localparam logic [CNT_W-1:0] STABLE_COUNT_RST = 16'd100;
    localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};

    // Configuration register indexes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_SETTLE_DELAY = 1'b0;
    localparam cfg_index_t CFG_STABLE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BLANK  = 2'd1,
        PH_SETTLE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [PIN_W-1:0] debounced_mask;
        phase_t           phase;
        logic [CNT_W-1:0] blank_remaining;
        logic [PIN_W-1:0] candidate_mask;
        logic [CNT_W-1:0] run_length;
    } swdb_state_t;

    localparam swdb_state_t STATE_RST = '{
        debounced_mask:  '0,
        phase:           PH_IDLE,
        blank_remaining: '0,
        candidate_mask:  '0,
        run_length:      '0
    };

endpackage

// ----- rtl/swdb_step.sv -----
// Per-sample next-state logic of the debouncer: blanking, settling, change event.
// Depends on swdb_pkg.
module swdb_step
(
    input  swdb_pkg::swdb_state_t             state_cur,
    input  logic [swdb_pkg::PIN_W-1:0]        pin_levels,
    input  logic [swdb_pkg::CNT_W-1:0]        settle_delay,
    input  logic [swdb_pkg::CNT_W-1:0]        stable_count,
    output swdb_pkg::swdb_state_t             state_nxt,
    output logic                              changed
);

    logic [swdb_pkg::PIN_W-1:0] pressed;
    logic [swdb_pkg::CNT_W-1:0] blank_dec;
    logic [swdb_pkg::CNT_W-1:0] need;
    logic [swdb_pkg::CNT_W-1:0] run_base;
    logic [swdb_pkg::CNT_W-1:0] run_inc;

    // Active-low pins become pressed bits
    assign pressed = ~pin_levels & swdb_pkg::SWITCH_MASK;

    // Counter helpers
    assign blank_dec = (state_cur.blank_remaining != '0) ?
                       state_cur.blank_remaining - 1'b1 : state_cur.blank_remaining;
    assign need      = (stable_count == '0) ? swdb_pkg::CNT_W'(1) : stable_count;
    assign run_base  = (pressed != state_cur.candidate_mask) ? '0 : state_cur.run_length;
    assign run_inc   = (run_base < swdb_pkg::CNT_MAX) ? run_base + 1'b1 : run_base;

    // Advance the phase machine by one sample
    always_comb
    begin
        state_nxt = state_cur;
        changed   = 1'b0;
        unique case (state_cur.phase)
            swdb_pkg::PH_BLANK:
            begin
                state_nxt.blank_remaining = blank_dec;
                if (blank_dec == '0)
                begin
                    state_nxt.phase          = swdb_pkg::PH_SETTLE;
                    state_nxt.candidate_mask = '0;
                    state_nxt.run_length     = '0;
                end
            end
            swdb_pkg::PH_SETTLE:
            begin
                state_nxt.candidate_mask = pressed;
                state_nxt.run_length     = run_inc;
                if (run_inc >= need)
                begin
                    changed                  = (pressed != state_cur.debounced_mask);
                    state_nxt.debounced_mask = pressed;
                    state_nxt.phase          = swdb_pkg::PH_IDLE;
                    state_nxt.run_length     = '0;
                end
            end
            default:
            begin
                state_nxt.phase = swdb_pkg::PH_IDLE;
                if (pressed != state_cur.debounced_mask)
                begin
                    if (settle_delay == '0)
                    begin
                        state_nxt.phase          = swdb_pkg::PH_SETTLE;
                        state_nxt.candidate_mask = '0;
                        state_nxt.run_length     = '0;
                    end
                    else
                    begin
                        state_nxt.phase           = swdb_pkg::PH_BLANK;
                        state_nxt.blank_remaining = settle_delay;
                    end
                end
            end
        endcase
    end

endmodule

// ----- rtl/switch_bank_debouncer.sv -----
// Switch bank debouncer: samples pass from the input register through the step
// logic into the result register and wait in the input register on a stall.
// Throughput is one sample per cycle without stalls (single-pass step logic).
// Reset clears the debounce state to idle with nothing pressed and loads
// settle_delay = 50 and stable_count = 100; no result is pending after reset.
// Depends on swdb_pkg, swdb_step and switch_bank_debouncer_macros.svh.
`include "switch_bank_debouncer_macros.svh"

module switch_bank_debouncer
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [swdb_pkg::PIN_W-1:0]   pin_levels,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [swdb_pkg::PIN_W-1:0]   pressed_now,
    output logic                         changed,
    output logic [swdb_pkg::PIN_W-1:0]   pressed_before,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  swdb_pkg::cfg_index_t         cfg_index,
    input  logic [swdb_pkg::CNT_W-1:0]   cfg_data
);

    logic [swdb_pkg::CNT_W-1:0] settle_delay_reg;
    logic [swdb_pkg::CNT_W-1:0] stable_count_reg;

    logic                       in_valid_reg;
    logic [swdb_pkg::PIN_W-1:0] pin_reg;

    swdb_pkg::swdb_state_t      state_reg;
    swdb_pkg::swdb_state_t      state_next;
    logic                       changed_next;

    logic                       out_valid_reg;
    logic [swdb_pkg::PIN_W-1:0] pressed_now_reg;
    logic                       changed_reg;
    logic [swdb_pkg::PIN_W-1:0] pressed_before_reg;

    logic                       out_load;
    logic                       step_fire;

    // Handshake: the result register frees when empty or when it transfers
    assign out_load  = !out_valid_reg || out_ready;
    assign step_fire = in_valid_reg && out_load;
    assign in_ready  = !in_valid_reg || out_load;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_delay_reg <= swdb_pkg::SETTLE_DELAY_RST;
            stable_count_reg <= swdb_pkg::STABLE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                swdb_pkg::CFG_SETTLE_DELAY: settle_delay_reg <= cfg_data;
                swdb_pkg::CFG_STABLE_COUNT: stable_count_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pin_reg <= pin_levels;
    end

    swdb_step u_step
    (
        .state_cur    (state_reg),
        .pin_levels   (pin_reg),
        .settle_delay (settle_delay_reg),
        .stable_count (stable_count_reg),
        .state_nxt    (state_next),
        .changed      (changed_next)
    );

    // Debounce state: advance once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= swdb_pkg::STATE_RST;
        else if (step_fire)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            pressed_now_reg    <= state_next.debounced_mask;
            changed_reg        <= changed_next;
            pressed_before_reg <= state_reg.debounced_mask;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pressed_now    = pressed_now_reg;
    assign changed        = changed_reg;
    assign pressed_before = pressed_before_reg;

    // A change event always reports two different masks, otherwise they match
    `SBD_ASSERT_IMPLIES(a_change_differs, out_valid && changed, pressed_now != pressed_before)
    `SBD_ASSERT_IMPLIES(a_nochange_equal, out_valid && !changed, pressed_now == pressed_before)
    // State only moves on a processed sample
    `SBD_ASSERT_NEXT(a_state_hold, !step_fire, $stable(state_reg))

endmodule
